// File: design/stoi_pkg.sv
package stoi_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int TIME_W        = 32;
    localparam int EPS_W         = 16;
    localparam int ADDR_W        = 2;
    localparam int DATA_W        = 32;

    localparam logic [EPS_W-1:0]  EPS_RESET = 16'd66;
    localparam logic [ADDR_W-1:0] REG_EPS   = 2'd0;

    typedef enum logic [2:0] {
        ST_HIT     = 3'd0,
        ST_OVERLAP = 3'd1,
        ST_STILL   = 3'd2,
        ST_SEP     = 3'd3,
        ST_MISS    = 3'd4,
        ST_LATER   = 3'd5
    } t_status;

    typedef struct packed {
        logic              hit;
        logic [TIME_W-1:0] time_out;
        t_status           status;
    } t_res;

endpackage

// File: design/stoi_sqrt.sv
module stoi_sqrt #(
    parameter int RW = 49,
    parameter int SW = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  logic [2*RW-1:0] i_rad,
    input  logic [SW-1:0]   i_side,
    output logic            o_vld,
    output logic [RW-1:0]   o_root,
    output logic [SW-1:0]   o_side
);

    localparam int NW = 2 * RW;
    localparam int TW = NW + 1;

    logic          r_vld  [RW];
    logic [NW-1:0] r_rem  [RW];
    logic [RW-1:0] r_root [RW];
    logic [SW-1:0] r_side [RW];

    genvar s;
    for (s = 0; s < RW; s++) begin : g_stage
        localparam int K = RW - 1 - s;
        logic          n_vld_in;
        logic [NW-1:0] n_rem_in;
        logic [RW-1:0] n_root_in;
        logic [SW-1:0] n_side_in;
        logic [TW-1:0] n_trial;
        logic          n_take;

        if (s == 0) begin : g_first
            assign n_vld_in  = i_vld;
            assign n_rem_in  = i_rad;
            assign n_root_in = '0;
            assign n_side_in = i_side;
        end else begin : g_next
            assign n_vld_in  = r_vld[s-1];
            assign n_rem_in  = r_rem[s-1];
            assign n_root_in = r_root[s-1];
            assign n_side_in = r_side[s-1];
        end

        // (r + 2^k)^2 - r^2
        assign n_trial = (TW'(n_root_in) << (K + 1)) + (TW'(1) << (2 * K));
        assign n_take  = {1'b0, n_rem_in} >= n_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= n_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_take ? NW'({1'b0, n_rem_in} - n_trial) : n_rem_in;
                r_root[s] <= n_take ? (n_root_in | (RW'(1) << K)) : n_root_in;
                r_side[s] <= n_side_in;
            end
        end
    end

    assign o_vld  = r_vld[RW-1];
    assign o_root = r_root[RW-1];
    assign o_side = r_side[RW-1];

endmodule

// File: design/stoi_div.sv
module stoi_div #(
    parameter int LW   = 65,
    parameter int DENW = 49,
    parameter int QW   = 32,
    parameter int SW   = 35
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  logic [LW-1:0]   i_num,
    input  logic [DENW-1:0] i_den,
    input  logic [SW-1:0]   i_side,
    output logic            o_vld,
    output logic [QW-1:0]   o_quot,
    output logic [SW-1:0]   o_side
);

    localparam int XW = DENW + QW;

    logic            r_vld  [QW];
    logic [LW-1:0]   r_rem  [QW];
    logic [DENW-1:0] r_den  [QW];
    logic [QW-1:0]   r_quot [QW];
    logic [SW-1:0]   r_side [QW];

    genvar s;
    for (s = 0; s < QW; s++) begin : g_stage
        localparam int J = QW - 1 - s;
        logic            n_vld_in;
        logic [LW-1:0]   n_rem_in;
        logic [DENW-1:0] n_den_in;
        logic [QW-1:0]   n_quot_in;
        logic [SW-1:0]   n_side_in;
        logic [XW-1:0]   n_trial;
        logic            n_take;

        if (s == 0) begin : g_first
            assign n_vld_in  = i_vld;
            assign n_rem_in  = i_num;
            assign n_den_in  = i_den;
            assign n_quot_in = '0;
            assign n_side_in = i_side;
        end else begin : g_next
            assign n_vld_in  = r_vld[s-1];
            assign n_rem_in  = r_rem[s-1];
            assign n_den_in  = r_den[s-1];
            assign n_quot_in = r_quot[s-1];
            assign n_side_in = r_side[s-1];
        end

        assign n_trial = XW'(n_den_in) << J;
        assign n_take  = XW'(n_rem_in) >= n_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= n_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_take ? LW'(XW'(n_rem_in) - n_trial) : n_rem_in;
                r_den[s]  <= n_den_in;
                r_quot[s] <= n_take ? (n_quot_in | (QW'(1) << J)) : n_quot_in;
                r_side[s] <= n_side_in;
            end
        end
    end

    assign o_vld  = r_vld[QW-1];
    assign o_quot = r_quot[QW-1];
    assign o_side = r_side[QW-1];

endmodule

// File: design/swept_circle_time_of_impact_top.sv
// channel   direction  handshake           payload
// input     in         i_valid / o_ready   i_a_x .. i_radius_b, i_time_in
// result    out        o_valid / i_ready   o_hit, o_time_out, o_status
// config    in         psel/penable/pwrite paddr, pwdata, prdata, pready
//
// one transaction accepted per cycle while the output buffer has a free entry; FRAC_BITS defaults to 16 (Q16.16)
// depth set by the bit-per-stage square root (65 - FRAC_BITS stages) and divider (32 stages)
// reset is synchronous: valid bits and the two-entry output buffer clear, epsilon goes to 66
// the pipeline freezes only while both output buffer entries hold a result
module swept_circle_time_of_impact_top #(
    parameter int FRAC_BITS = stoi_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [stoi_pkg::ADDR_W-1:0] paddr,
    input  logic [stoi_pkg::DATA_W-1:0] pwdata,
    output logic [stoi_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [31:0]          i_a_x,
    input  logic signed [31:0]          i_a_y,
    input  logic signed [31:0]          i_a_dx,
    input  logic signed [31:0]          i_a_dy,
    input  logic [30:0]                 i_radius_a,
    input  logic signed [31:0]          i_b_x,
    input  logic signed [31:0]          i_b_y,
    input  logic signed [31:0]          i_b_dx,
    input  logic signed [31:0]          i_b_dy,
    input  logic [30:0]                 i_radius_b,
    input  logic [31:0]                 i_time_in,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_hit,
    output logic [31:0]                 o_time_out,
    output logic [2:0]                  o_status
);

    import stoi_pkg::*;

    localparam int PW  = 64 - FRAC_BITS;
    localparam int AW  = PW + 1;
    localparam int CW  = PW + 2;
    localparam int DW  = 2 * AW;
    localparam int HW  = (AW + 1) / 2;
    localparam int GW  = AW - HW;
    localparam int LW  = AW + FRAC_BITS;
    localparam int XW  = AW + TIME_W;
    localparam int SQW = 2 * AW + TIME_W + 3;
    localparam int DVW = TIME_W + 3;

    // configuration
    logic [EPS_W-1:0] r_eps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_RESET;
        end else if (psel && penable && pwrite && paddr == REG_EPS) begin
            r_eps <= pwdata[EPS_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_EPS) ? DATA_W'(r_eps) : '0;

    logic       w_en;
    logic [1:0] r_cnt;

    assign w_en    = (r_cnt != 2'd2);
    assign o_ready = w_en;

    // stage 1: offsets, velocities, magnitudes
    logic signed [32:0] n1_dx, n1_dy, n1_vx, n1_vy;
    logic        r1_vld;
    logic [31:0] r1_dxm, r1_dym, r1_vxm, r1_vym, r1_rs, r1_time;
    logic        r1_sdx, r1_sdy, r1_svx, r1_svy;

    assign n1_dx = 33'(i_b_x) - 33'(i_a_x);
    assign n1_dy = 33'(i_b_y) - 33'(i_a_y);
    assign n1_vx = 33'(i_b_dx) - 33'(i_a_dx);
    assign n1_vy = 33'(i_b_dy) - 33'(i_a_dy);

    // stage 2: scaled products
    logic [63:0] n2_pdx, n2_pdy, n2_pvx, n2_pvy, n2_pbx, n2_pby, n2_prr;
    logic          r2_vld;
    logic [PW-1:0] r2_pdx, r2_pdy, r2_pvx, r2_pvy, r2_pbx, r2_pby, r2_prr;
    logic          r2_sbx, r2_sby;
    logic [31:0]   r2_time;

    assign n2_pdx = {32'd0, r1_dxm} * {32'd0, r1_dxm};
    assign n2_pdy = {32'd0, r1_dym} * {32'd0, r1_dym};
    assign n2_pvx = {32'd0, r1_vxm} * {32'd0, r1_vxm};
    assign n2_pvy = {32'd0, r1_vym} * {32'd0, r1_vym};
    assign n2_pbx = {32'd0, r1_dxm} * {32'd0, r1_vxm};
    assign n2_pby = {32'd0, r1_dym} * {32'd0, r1_vym};
    assign n2_prr = {32'd0, r1_rs} * {32'd0, r1_rs};

    // stage 3: quadratic terms
    logic [AW-1:0]        n3_a, n3_dd;
    logic signed [CW-1:0] n3_c, n3_bx, n3_by, n3_b;
    logic                 r3_vld;
    logic [AW-1:0]        r3_a;
    logic signed [CW-1:0] r3_b, r3_c;
    logic [31:0]          r3_time;

    assign n3_a  = AW'(r2_pvx) + AW'(r2_pvy);
    assign n3_dd = AW'(r2_pdx) + AW'(r2_pdy);
    assign n3_c  = $signed({1'b0, n3_dd}) - $signed({2'b00, r2_prr});
    assign n3_bx = r2_sbx ? -$signed({2'b00, r2_pbx}) : $signed({2'b00, r2_pbx});
    assign n3_by = r2_sby ? -$signed({2'b00, r2_pby}) : $signed({2'b00, r2_pby});
    assign n3_b  = n3_bx + n3_by;

    // stage 4: early cases, magnitudes
    t_status       n4_st;
    logic          r4_vld;
    logic [AW-1:0] r4_bm, r4_cm, r4_a;
    logic [31:0]   r4_time;
    t_status       r4_st;

    always_comb begin
        if (r3_c[CW-1]) begin
            n4_st = ST_OVERLAP;
        end else if (r3_a == '0 || r3_a < AW'(r_eps)) begin
            n4_st = ST_STILL;
        end else if (!r3_b[CW-1]) begin
            n4_st = ST_SEP;
        end else begin
            n4_st = ST_HIT;
        end
    end

    // stage 5: partial products of b*b and a*c
    logic            r5_vld;
    logic [2*HW-1:0] r5_bll, r5_all;
    logic [AW-1:0]   r5_blh, r5_alh, r5_ahl;
    logic [2*GW-1:0] r5_bhh, r5_ahh;
    logic [AW-1:0]   r5_bm, r5_a;
    logic [31:0]     r5_time;
    t_status         r5_st;

    // stage 6: full products
    logic [DW-1:0] n6_b2, n6_ac;
    logic          r6_vld;
    logic [DW-1:0] r6_b2, r6_ac;
    logic [AW-1:0] r6_bm, r6_a;
    logic [31:0]   r6_time;
    t_status       r6_st;

    assign n6_b2 = (DW'(r5_bhh) << (2 * HW)) + (DW'(r5_blh) << (HW + 1)) + DW'(r5_bll);
    assign n6_ac = (DW'(r5_ahh) << (2 * HW)) + (DW'(r5_alh) << HW)
                 + (DW'(r5_ahl) << HW) + DW'(r5_all);

    // stage 7: discriminant
    logic [DW:0]   n7_d;
    t_status       n7_st;
    logic          r7_vld;
    logic [DW-1:0] r7_disc;
    logic [AW-1:0] r7_bm, r7_a;
    logic [31:0]   r7_time;
    t_status       r7_st;

    assign n7_d  = {1'b0, r6_b2} - {1'b0, r6_ac};
    assign n7_st = (r6_st == ST_HIT && n7_d[DW]) ? ST_MISS : r6_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_dxm  <= n1_dx[32] ? 32'(-n1_dx) : n1_dx[31:0];
            r1_dym  <= n1_dy[32] ? 32'(-n1_dy) : n1_dy[31:0];
            r1_vxm  <= n1_vx[32] ? 32'(-n1_vx) : n1_vx[31:0];
            r1_vym  <= n1_vy[32] ? 32'(-n1_vy) : n1_vy[31:0];
            r1_sdx  <= n1_dx[32];
            r1_sdy  <= n1_dy[32];
            r1_svx  <= n1_vx[32];
            r1_svy  <= n1_vy[32];
            r1_rs   <= 32'(i_radius_a) + 32'(i_radius_b);
            r1_time <= i_time_in;

            r2_pdx  <= n2_pdx[63:FRAC_BITS];
            r2_pdy  <= n2_pdy[63:FRAC_BITS];
            r2_pvx  <= n2_pvx[63:FRAC_BITS];
            r2_pvy  <= n2_pvy[63:FRAC_BITS];
            r2_pbx  <= n2_pbx[63:FRAC_BITS];
            r2_pby  <= n2_pby[63:FRAC_BITS];
            r2_prr  <= n2_prr[63:FRAC_BITS];
            r2_sbx  <= r1_sdx ^ r1_svx;
            r2_sby  <= r1_sdy ^ r1_svy;
            r2_time <= r1_time;

            r3_a    <= n3_a;
            r3_b    <= n3_b;
            r3_c    <= n3_c;
            r3_time <= r2_time;

            r4_bm   <= AW'(-r3_b);
            r4_cm   <= r3_c[AW-1:0];
            r4_a    <= r3_a;
            r4_time <= r3_time;
            r4_st   <= n4_st;

            r5_bll  <= {{HW{1'b0}}, r4_bm[HW-1:0]} * {{HW{1'b0}}, r4_bm[HW-1:0]};
            r5_blh  <= {{GW{1'b0}}, r4_bm[HW-1:0]} * {{HW{1'b0}}, r4_bm[AW-1:HW]};
            r5_bhh  <= {{GW{1'b0}}, r4_bm[AW-1:HW]} * {{GW{1'b0}}, r4_bm[AW-1:HW]};
            r5_all  <= {{HW{1'b0}}, r4_a[HW-1:0]} * {{HW{1'b0}}, r4_cm[HW-1:0]};
            r5_alh  <= {{GW{1'b0}}, r4_a[HW-1:0]} * {{HW{1'b0}}, r4_cm[AW-1:HW]};
            r5_ahl  <= {{HW{1'b0}}, r4_a[AW-1:HW]} * {{GW{1'b0}}, r4_cm[HW-1:0]};
            r5_ahh  <= {{GW{1'b0}}, r4_a[AW-1:HW]} * {{GW{1'b0}}, r4_cm[AW-1:HW]};
            r5_bm   <= r4_bm;
            r5_a    <= r4_a;
            r5_time <= r4_time;
            r5_st   <= r4_st;

            r6_b2   <= n6_b2;
            r6_ac   <= n6_ac;
            r6_bm   <= r5_bm;
            r6_a    <= r5_a;
            r6_time <= r5_time;
            r6_st   <= r5_st;

            r7_disc <= n7_d[DW-1:0];
            r7_bm   <= r6_bm;
            r7_a    <= r6_a;
            r7_time <= r6_time;
            r7_st   <= n7_st;
        end
    end

    // square root of the discriminant
    logic           w_sq_vld;
    logic [AW-1:0]  w_root;
    logic [SQW-1:0] w_sq_side;
    logic [AW-1:0]  w_sq_bm, w_sq_a;
    logic [31:0]    w_sq_time;
    t_status        w_sq_st;

    stoi_sqrt #(
        .RW (AW),
        .SW (SQW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r7_vld),
        .i_rad   (r7_disc),
        .i_side  ({r7_bm, r7_a, r7_time, r7_st}),
        .o_vld   (w_sq_vld),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    assign w_sq_bm   = w_sq_side[SQW-1 -: AW];
    assign w_sq_a    = w_sq_side[SQW-AW-1 -: AW];
    assign w_sq_time = w_sq_side[TIME_W+2:3];
    assign w_sq_st   = t_status'(w_sq_side[2:0]);

    // stage 8: numerator, range check against 2^32 * a
    logic [AW-1:0] n8_num;
    logic [LW-1:0] n8_lhs;
    t_status       n8_st;
    logic          r8_vld;
    logic [LW-1:0] r8_lhs;
    logic [AW-1:0] r8_a;
    logic [31:0]   r8_time;
    t_status       r8_st;

    assign n8_num = w_sq_bm - w_root;
    assign n8_lhs = LW'(n8_num) << FRAC_BITS;
    assign n8_st  = (w_sq_st == ST_HIT && XW'(n8_lhs) >= (XW'(w_sq_a) << TIME_W))
                  ? ST_LATER : w_sq_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else if (w_en) begin
            r8_vld <= w_sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_lhs  <= n8_lhs;
            r8_a    <= w_sq_a;
            r8_time <= w_sq_time;
            r8_st   <= n8_st;
        end
    end

    // time quotient
    logic           w_dv_vld;
    logic [31:0]    w_quot;
    logic [DVW-1:0] w_dv_side;
    logic [31:0]    w_dv_time;
    t_status        w_dv_st;

    stoi_div #(
        .LW   (LW),
        .DENW (AW),
        .QW   (TIME_W),
        .SW   (DVW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r8_vld),
        .i_num   (r8_lhs),
        .i_den   (r8_a),
        .i_side  ({r8_time, r8_st}),
        .o_vld   (w_dv_vld),
        .o_quot  (w_quot),
        .o_side  (w_dv_side)
    );

    assign w_dv_time = w_dv_side[DVW-1:3];
    assign w_dv_st   = t_status'(w_dv_side[2:0]);

    // final decision
    t_res n_res;

    always_comb begin
        n_res.hit      = 1'b0;
        n_res.time_out = w_dv_time;
        n_res.status   = w_dv_st;
        if (w_dv_st == ST_HIT) begin
            if (w_quot >= w_dv_time) begin
                n_res.status = ST_LATER;
            end else begin
                n_res.hit      = 1'b1;
                n_res.time_out = (w_quot > TIME_W'(r_eps)) ? w_quot - TIME_W'(r_eps) : '0;
            end
        end
    end

    // two-entry output buffer
    t_res       r_e0, r_e1;
    logic       n_push, n_pop;
    logic [1:0] n_cnt;

    assign n_push = w_en && w_dv_vld;
    assign n_pop  = o_valid && i_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (n_push && !n_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (n_pop && !n_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_push && !n_pop) begin
            if (r_cnt == 2'd0) begin
                r_e0 <= n_res;
            end else begin
                r_e1 <= n_res;
            end
        end else if (n_pop && !n_push) begin
            r_e0 <= r_e1;
        end else if (n_pop && n_push) begin
            if (r_cnt == 2'd1) begin
                r_e0 <= n_res;
            end else begin
                r_e0 <= r_e1;
                r_e1 <= n_res;
            end
        end
    end

    assign o_valid    = (r_cnt != 2'd0);
    assign o_hit      = r_e0.hit;
    assign o_time_out = r_e0.time_out;
    assign o_status   = r_e0.status;

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output buffer count out of range");

    a_hit_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hit == (o_status == ST_HIT)))
        else $error("hit flag and status disagree");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status <= ST_LATER))
        else $error("undefined status code");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !i_ready) |=> ($stable(r8_lhs) && $stable(r8_vld)))
        else $error("pipeline moved while output buffer full");
`endif

endmodule

// File: tb/sv/tb_swept_circle_time_of_impact_top.sv
`timescale 1ns / 100ps

module tb_swept_circle_time_of_impact_top;
    import stoi_pkg::*;

    localparam int ONE = 65536;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 120;

    typedef struct {
        logic signed [31:0] ax, ay, adx, ady, bx, by, bdx, bdy;
        logic [30:0] ra, rb;
        logic [31:0] tin;
    } t_pair;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;
    logic i_valid = 1'b0;
    logic o_ready;
    logic signed [31:0] i_a_x = '0, i_a_y = '0, i_a_dx = '0, i_a_dy = '0;
    logic signed [31:0] i_b_x = '0, i_b_y = '0, i_b_dx = '0, i_b_dy = '0;
    logic [30:0] i_radius_a = '0, i_radius_b = '0;
    logic [31:0] i_time_in = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic o_hit;
    logic [31:0] o_time_out;
    logic [2:0] o_status;

    swept_circle_time_of_impact_top dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    logic [EPS_W-1:0] eps_shadow = EPS_RESET;
    t_res expected_toi[$];
    int fail_count = 0;
    int sent_count = 0;
    int checked_count = 0;
    int status_seen[6];
    bit no_idle = 1'b0;
    int quiet_cycles = 0;

    function automatic longint trunc_prod(longint p, longint q);
        logic [127:0] mp, mq, m;
        mp = 128'((p < 0) ? -p : p);
        mq = 128'((q < 0) ? -q : q);
        m = (mp * mq) >> 16;
        return ((p < 0) != (q < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [127:0] isqrt(logic [127:0] n);
        logic [127:0] r, cand;
        r = '0;
        for (int bit_i = 58; bit_i >= 0; bit_i--) begin
            cand = r | (128'd1 << bit_i);
            if (cand * cand <= n) r = cand;
        end
        return r;
    endfunction

    function automatic t_res predict_toi(t_pair p, logic [EPS_W-1:0] eps);
        longint dx, dy, vx, vy, a, b, c;
        logic [127:0] rs, bm, b2, ac, num, lhs, rhs, q;
        t_res r;
        dx = longint'(p.bx) - longint'(p.ax);
        dy = longint'(p.by) - longint'(p.ay);
        vx = longint'(p.bdx) - longint'(p.adx);
        vy = longint'(p.bdy) - longint'(p.ady);
        rs = 128'(p.ra) + 128'(p.rb);
        c = trunc_prod(dx, dx) + trunc_prod(dy, dy) - longint'((rs * rs) >> 16);
        r.hit = 1'b0;
        r.time_out = p.tin;
        if (c < 0) begin
            r.status = ST_OVERLAP;
        end else begin
            a = trunc_prod(vx, vx) + trunc_prod(vy, vy);
            if (a == 0 || a < longint'(eps)) begin
                r.status = ST_STILL;
            end else begin
                b = trunc_prod(dx, vx) + trunc_prod(dy, vy);
                if (b >= 0) begin
                    r.status = ST_SEP;
                end else begin
                    bm = 128'(-b);
                    b2 = bm * bm;
                    ac = 128'(a) * 128'(c);
                    if (b2 < ac) begin
                        r.status = ST_MISS;
                    end else begin
                        num = bm - isqrt(b2 - ac);
                        lhs = num << 16;
                        rhs = 128'(p.tin) * 128'(a);
                        if (lhs >= rhs) begin
                            r.status = ST_LATER;
                        end else begin
                            q = lhs / 128'(a);
                            r.time_out = (q > 128'(eps)) ? 32'(q - 128'(eps)) : 32'd0;
                            r.hit = 1'b1;
                            r.status = ST_HIT;
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic send_pair(t_pair p);
        if (!no_idle) begin
            while ($urandom_range(0, 99) < 6) begin
                i_valid = 1'b0;
                @(negedge i_clk);
            end
        end
        i_a_x = p.ax; i_a_y = p.ay; i_a_dx = p.adx; i_a_dy = p.ady;
        i_radius_a = p.ra;
        i_b_x = p.bx; i_b_y = p.by; i_b_dx = p.bdx; i_b_dy = p.bdy;
        i_radius_b = p.rb;
        i_time_in = p.tin;
        i_valid = 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_toi.push_back(predict_toi(p, eps_shadow));
        sent_count++;
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    function automatic t_pair mk_pair(int ax, int ay, int adx, int ady, int ra,
                                      int bx, int by, int bdx, int bdy, int rb,
                                      logic [31:0] tin);
        t_pair p;
        p.ax = ax; p.ay = ay; p.adx = adx; p.ady = ady; p.ra = 31'(ra);
        p.bx = bx; p.by = by; p.bdx = bdx; p.bdy = bdy; p.rb = 31'(rb);
        p.tin = tin;
        return p;
    endfunction

    function automatic int srand(int range);
        return int'($urandom_range(0, 2 * range)) - range;
    endfunction

    function automatic t_pair random_pair();
        t_pair p;
        int ox, oy;
        if ($urandom_range(0, 99) < 30) begin
            p.ax = $urandom; p.ay = $urandom; p.adx = $urandom; p.ady = $urandom;
            p.bx = $urandom; p.by = $urandom; p.bdx = $urandom; p.bdy = $urandom;
            p.ra = 31'($urandom); p.rb = 31'($urandom); p.tin = $urandom;
        end else begin
            ox = srand(1 << 22);
            oy = srand(1 << 22);
            p.ax = srand(1 << 26);
            p.ay = srand(1 << 26);
            p.adx = srand(1 << 20);
            p.ady = srand(1 << 20);
            p.bx = p.ax + ox;
            p.by = p.ay + oy;
            p.bdx = p.adx - ox / int'($urandom_range(1, 4)) + srand(1 << 18);
            p.bdy = p.ady - oy / int'($urandom_range(1, 4)) + srand(1 << 18);
            p.ra = 31'($urandom_range(0, 1 << 21));
            p.rb = 31'($urandom_range(0, 1 << 21));
            case ($urandom_range(0, 3))
                0: p.tin = ONE;
                1: p.tin = $urandom_range(0, ONE);
                2: p.tin = 32'hFFFF_FFFF;
                default: p.tin = $urandom;
            endcase
        end
        return p;
    endfunction

    task automatic wait_drained();
        while (expected_toi.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apb_access(logic wr, logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
        psel = 1'b1; penable = 1'b0; pwrite = wr; paddr = REG_EPS; pwdata = wdata;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    task automatic set_epsilon(logic [EPS_W-1:0] eps);
        logic [DATA_W-1:0] rd;
        wait_drained();
        apb_access(1'b1, DATA_W'(eps), rd);
        eps_shadow = eps;
        apb_access(1'b0, '0, rd);
        if (rd[EPS_W-1:0] !== eps) begin
            $error("epsilon readback expected %0d actual %0d", eps, rd[EPS_W-1:0]);
            fail_count++;
        end
    endtask

    task automatic test_directed();
        send_pair(mk_pair(0, 0, 0, 0, ONE, ONE, 0, 0, 0, ONE, ONE));
        send_pair(mk_pair(0, 0, 0, 0, ONE, 10 * ONE, 0, 0, 0, ONE, ONE));
        send_pair(mk_pair(0, 0, 0, 0, ONE, 10 * ONE, 0, ONE, 0, ONE, ONE));
        send_pair(mk_pair(0, 0, 0, 0, ONE, 10 * ONE, 5 * ONE, -20 * ONE, 0, ONE, ONE));
        send_pair(mk_pair(0, 0, 0, 0, ONE, 10 * ONE, 0, -20 * ONE, 0, ONE, ONE));
        send_pair(mk_pair(0, 0, 0, 0, ONE, 10 * ONE, 0, -20 * ONE, 0, ONE, 32'h1000));
        send_pair(mk_pair(0, 0, 0, 0, ONE, 10 * ONE, 0, -20 * ONE, 0, ONE, 32'hFFFF_FFFF));
        send_pair(mk_pair(0, 0, 0, 0, ONE, 2 * ONE, 0, -ONE, 0, ONE, ONE));
        send_pair(mk_pair(0, 0, 5 * ONE, 5 * ONE, ONE, 10 * ONE, 10 * ONE, -5 * ONE,
                          -5 * ONE, ONE, ONE));
        send_pair(mk_pair(0, 0, 0, 0, 0, 3, 0, -1, 0, 0, ONE));
        send_pair(mk_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          31'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 31'h7FFF_FFFF, 32'hFFFF_FFFF));
        send_pair(mk_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'h8000_0000, 0, 32'hFFFF_FFFF));
        send_pair(mk_pair(32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 0,
                          32'h8000_0000, 0, 0, 0));
        send_pair(mk_pair(0, 0, 0, 0, 31'h7FFF_FFFF, 0, 0, 0, 0, 31'h7FFF_FFFF, 0));
        send_pair(mk_pair(-1, -1, -1, -1, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    endtask

    task automatic test_slow_motion();
        send_pair(mk_pair(0, 0, 0, 0, ONE, 10 * ONE, 0, -64, 0, ONE, 32'hFFFF_FFFF));
        send_pair(mk_pair(0, 0, 0, 0, ONE, 10 * ONE, 0, -300, 0, ONE, 32'hFFFF_FFFF));
        send_pair(mk_pair(0, 0, 0, 0, ONE, 10 * ONE, 0, -ONE * 200, 0, ONE, ONE));
        for (int k = 0; k < 40; k++) send_pair(random_pair());
    endtask

    task automatic test_random(int count);
        for (int k = 0; k < count; k++) begin
            no_idle = (k >= count / 3) && (k < count / 3 + 150);
            send_pair(random_pair());
        end
        no_idle = 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else i_ready <= no_idle || ($urandom_range(0, 99) >= 6);
    end

    always @(posedge i_clk) begin
        t_res exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_toi.size() == 0) begin
                $error("result with nothing expected");
                fail_count++;
            end else begin
                exp_r = expected_toi.pop_front();
                checked_count++;
                if (o_status < 6) status_seen[o_status]++;
                if (o_hit !== exp_r.hit) begin
                    $error("hit expected %0d actual %0d", exp_r.hit, o_hit);
                    fail_count++;
                end
                if (o_time_out !== exp_r.time_out) begin
                    $error("time_out expected %0h actual %0h", exp_r.time_out, o_time_out);
                    fail_count++;
                end
                if (o_status !== exp_r.status) begin
                    $error("status expected %0d actual %0d", exp_r.status, o_status);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || psel || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_slow_motion();
        test_random(400);
        set_epsilon(16'd0);
        test_directed();
        test_random(400);
        set_epsilon(16'hFFFF);
        test_slow_motion();
        test_random(400);
        set_epsilon(16'($urandom));
        test_random(400);
        set_epsilon(EPS_RESET);
        wait_drained();
        if (expected_toi.size() != 0) fail_count++;
        $display("sent %0d circle pairs, checked %0d results over 4 epsilon settings",
                 sent_count, checked_count);
        $display("status counts hit/overlap/still/sep/miss/later: %0d %0d %0d %0d %0d %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5]);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
